// ===== rtl/core/scan_polar_to_cartesian_top_macros.svh =====
// assertion macros shared by the converter modules
`ifndef SCAN_POLAR_TO_CARTESIAN_TOP_MACROS_SVH
`define SCAN_POLAR_TO_CARTESIAN_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// consequence must hold in the same cycle
`define SPTC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence must hold in the next cycle
`define SPTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SPTC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define SPTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/sptc_pkg.sv =====
package sptc_pkg;

    // field and datapath widths
    localparam int RANGE_W = 16;
    localparam int COORD_W = 17;
    localparam int IDX_W   = 12;
    localparam int CNT_W   = 13;
    localparam int ANGLE_W = 32;
    localparam int XY_W    = 34;
    localparam int RND_W   = 18;

    // inverse cordic gain, unsigned q0.32
    localparam logic [31:0] GAIN_Q32 = 32'd2608131496;
    // eighth of a turn, used to pick the nearest quadrant
    localparam logic [ANGLE_W-1:0] EIGHTH_TURN = 32'h2000_0000;
    localparam logic [CNT_W-1:0] COUNT_MAX = 13'd8191;
    localparam logic [CNT_W-1:0] INDEX_CAP = 13'd4096;
    localparam logic [15:0] HEIGHT_RESET = 16'd70;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 17'sd65535;
    localparam logic signed [COORD_W-1:0] COORD_MIN = -17'sd65535;

    // configuration register indexes
    localparam logic [1:0] CFG_ANGLE_START = 2'd0;
    localparam logic [1:0] CFG_ANGLE_STEP  = 2'd1;
    localparam logic [1:0] CFG_POINTS      = 2'd2;
    localparam logic [1:0] CFG_HEIGHT      = 2'd3;

    // quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle_start;
        logic [ANGLE_W-1:0] angle_step;
        logic [CNT_W-1:0]   points;
        logic [15:0]        height;
    } t_cfg;

    typedef struct packed {
        logic signed [XY_W-1:0]    x;
        logic signed [XY_W-1:0]    y;
        logic signed [ANGLE_W-1:0] z;
        logic [1:0]                quad;
        logic [IDX_W-1:0]          idx;
        logic                      sensor;
        logic                      last;
    } t_point;

    typedef struct packed {
        logic   valid;
        t_point pt;
    } t_stage;

    // arctangent of 2^-i in 2^32-per-turn units
    function automatic logic [ANGLE_W-1:0] atan_turn(input logic [4:0] i);
        logic [ANGLE_W-1:0] v;
        unique case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            5'd31: v = 32'd0;
            default: v = '0;
        endcase
        return v;
    endfunction

    // clamp a rounded coordinate to +-65535
    function automatic logic signed [COORD_W-1:0] sat_mm(input logic signed [RND_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > RND_W'(COORD_MAX)) begin
            r = COORD_MAX;
        end else if (v < RND_W'(COORD_MIN)) begin
            r = COORD_MIN;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/sptc_if.sv =====
// range sample channel
interface sptc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] range_mm;
    logic        scan_start;
    logic        sensor_in;

    modport source (output valid, output range_mm, output scan_start, output sensor_in,
                    input ready);
    modport sink   (input valid, input range_mm, input scan_start, input sensor_in,
                    output ready);
endinterface

// cartesian point channel
interface sptc_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] x_mm;
    logic signed [16:0] y_mm;
    logic [15:0]        z_mm;
    logic [11:0]        point_index;
    logic               sensor_out;
    logic               last_point;

    modport source (output valid, output x_mm, output y_mm, output z_mm,
                    output point_index, output sensor_out, output last_point,
                    input ready);
    modport sink   (input valid, input x_mm, input y_mm, input z_mm,
                    input point_index, input sensor_out, input last_point,
                    output ready);
endinterface

// register write channel
interface sptc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/sptc_front.sv =====
`include "scan_polar_to_cartesian_top_macros.svh"

module sptc_front #(
    parameter int MAX_POINTS = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sptc_in_if.sink          i_scan,
    input  sptc_pkg::t_cfg   i_cfg,
    input  logic             i_adv_dn,
    output sptc_pkg::t_stage o_stage
);

    localparam int LIM_I = (MAX_POINTS < 4096) ? MAX_POINTS : 4096;
    localparam logic [sptc_pkg::CNT_W-1:0] LIM_MAX = sptc_pkg::CNT_W'(LIM_I);

    logic                              r_valid;
    sptc_pkg::t_point                  r_pt;
    logic [sptc_pkg::CNT_W-1:0]        r_count;
    logic [sptc_pkg::ANGLE_W-1:0]      r_acc;

    logic                              w_take;
    logic [sptc_pkg::CNT_W-1:0]        w_idx;
    logic [sptc_pkg::ANGLE_W-1:0]      w_acc;
    logic [sptc_pkg::CNT_W-1:0]        w_limit;
    logic                              w_keep;
    logic                              w_last;
    logic [sptc_pkg::ANGLE_W-1:0]      w_angle;
    logic [sptc_pkg::ANGLE_W-1:0]      w_fold;
    logic [1:0]                        w_quad;
    logic [sptc_pkg::ANGLE_W-1:0]      w_res;
    logic [47:0]                       w_prod;
    logic [47:0]                       w_rnd;
    logic [sptc_pkg::CNT_W-1:0]        n_count;
    logic [sptc_pkg::ANGLE_W-1:0]      n_acc;

    // stage takes a new item when empty or when the first cell moves on
    assign i_scan.ready = !r_valid || i_adv_dn;
    assign w_take       = i_scan.valid && i_scan.ready;

    // index, limit and angle of the incoming sample
    always_comb begin
        w_idx   = i_scan.scan_start ? '0 : r_count;
        w_acc   = i_scan.scan_start ? '0 : r_acc;
        w_limit = (i_cfg.points < LIM_MAX) ? i_cfg.points : LIM_MAX;
        w_keep  = w_idx < w_limit;
        w_last  = ({1'b0, w_idx} + 14'd1) == {1'b0, w_limit};
        w_angle = i_cfg.angle_start + w_acc;
        w_fold  = w_angle + sptc_pkg::EIGHTH_TURN;
        w_quad  = w_fold[31:30];
        w_res   = w_angle - {w_quad, 30'd0};
        n_count = (w_idx < sptc_pkg::COUNT_MAX) ? w_idx + 13'd1 : w_idx;
        n_acc   = w_acc + i_cfg.angle_step;
    end

    // gain-compensated start vector in q16
    assign w_prod = 48'(i_scan.range_mm) * 48'(sptc_pkg::GAIN_Q32);
    assign w_rnd  = w_prod + 48'd32768;

    // scan state and stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
            r_acc   <= '0;
        end else begin
            if (w_take) begin
                r_count <= n_count;
                r_acc   <= n_acc;
            end
            if (i_scan.ready) begin
                r_valid <= w_take && w_keep;
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pt.x      <= {2'b00, w_rnd[47:16]};
            r_pt.y      <= '0;
            r_pt.z      <= w_res;
            r_pt.quad   <= w_quad;
            r_pt.idx    <= w_idx[sptc_pkg::IDX_W-1:0];
            r_pt.sensor <= i_scan.sensor_in;
            r_pt.last   <= w_last;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.pt    = r_pt;

    `SPTC_ASSERT_NEXT(a_count_steps, i_clk, i_rst_n,
        w_take && !i_scan.scan_start && (r_count != sptc_pkg::COUNT_MAX),
        r_count == $past(r_count) + 13'd1, "sample index did not advance")
    `SPTC_ASSERT_NEXT(a_start_index, i_clk, i_rst_n,
        w_take && i_scan.scan_start && (w_limit != '0),
        r_valid && (r_pt.idx == '0), "scan start did not restart the index")

endmodule

// ===== rtl/core/sptc_cell.sv =====
module sptc_cell #(
    parameter int STAGE = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sptc_pkg::t_stage i_stage,
    input  logic             i_adv_dn,
    output logic             o_adv_up,
    output sptc_pkg::t_stage o_stage
);

    logic                                r_valid;
    sptc_pkg::t_point                    r_pt;
    sptc_pkg::t_point                    w_pt;
    logic signed [sptc_pkg::XY_W-1:0]    w_dx;
    logic signed [sptc_pkg::XY_W-1:0]    w_dy;
    logic signed [sptc_pkg::ANGLE_W-1:0] w_atan;

    assign o_adv_up = !r_valid || i_adv_dn;

    // one micro-rotation, direction from the sign of the remaining angle
    always_comb begin
        w_dx   = $signed(i_stage.pt.y) >>> STAGE;
        w_dy   = $signed(i_stage.pt.x) >>> STAGE;
        w_atan = $signed(sptc_pkg::atan_turn(5'(STAGE)));
        w_pt   = i_stage.pt;
        if (!i_stage.pt.z[sptc_pkg::ANGLE_W-1]) begin
            w_pt.x = i_stage.pt.x - w_dx;
            w_pt.y = i_stage.pt.y + w_dy;
            w_pt.z = i_stage.pt.z - w_atan;
        end else begin
            w_pt.x = i_stage.pt.x + w_dx;
            w_pt.y = i_stage.pt.y - w_dy;
            w_pt.z = i_stage.pt.z + w_atan;
        end
    end

    // cell valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv_up) begin
            r_valid <= i_stage.valid;
        end
    end

    // cell payload
    always_ff @(posedge i_clk) begin
        if (o_adv_up && i_stage.valid) begin
            r_pt <= w_pt;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.pt    = r_pt;

endmodule

// ===== rtl/core/sptc_back.sv =====
`include "scan_polar_to_cartesian_top_macros.svh"

module sptc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sptc_pkg::t_stage i_stage,
    input  logic [15:0]      i_height,
    output logic             o_adv_up,
    sptc_out_if.source       o_point
);

    logic                                r_valid;
    logic signed [sptc_pkg::COORD_W-1:0] r_x;
    logic signed [sptc_pkg::COORD_W-1:0] r_y;
    logic [sptc_pkg::IDX_W-1:0]          r_idx;
    logic                                r_sensor;
    logic                                r_last;

    logic signed [sptc_pkg::XY_W-1:0]    w_xr;
    logic signed [sptc_pkg::XY_W-1:0]    w_yr;
    logic signed [sptc_pkg::RND_W-1:0]   w_xi;
    logic signed [sptc_pkg::RND_W-1:0]   w_yi;
    logic signed [sptc_pkg::RND_W-1:0]   w_xq;
    logic signed [sptc_pkg::RND_W-1:0]   w_yq;

    assign o_adv_up = !r_valid || o_point.ready;

    // round q16 to whole millimetres
    always_comb begin
        w_xr = i_stage.pt.x + 34'sd32768;
        w_yr = i_stage.pt.y + 34'sd32768;
        w_xi = w_xr[sptc_pkg::XY_W-1:16];
        w_yi = w_yr[sptc_pkg::XY_W-1:16];
    end

    // exact quarter-turn rotation back to the true quadrant
    always_comb begin
        case (i_stage.pt.quad)
            sptc_pkg::QUAD_0: begin
                w_xq = w_xi;
                w_yq = w_yi;
            end
            sptc_pkg::QUAD_1: begin
                w_xq = -w_yi;
                w_yq = w_xi;
            end
            sptc_pkg::QUAD_2: begin
                w_xq = -w_xi;
                w_yq = -w_yi;
            end
            default: begin
                w_xq = w_yi;
                w_yq = -w_xi;
            end
        endcase
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv_up) begin
            r_valid <= i_stage.valid;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (o_adv_up && i_stage.valid) begin
            r_x      <= sptc_pkg::sat_mm(w_xq);
            r_y      <= sptc_pkg::sat_mm(w_yq);
            r_idx    <= i_stage.pt.idx;
            r_sensor <= i_stage.pt.sensor;
            r_last   <= i_stage.pt.last;
        end
    end

    assign o_point.valid       = r_valid;
    assign o_point.x_mm        = r_x;
    assign o_point.y_mm        = r_y;
    assign o_point.z_mm        = i_height;
    assign o_point.point_index = r_idx;
    assign o_point.sensor_out  = r_sensor;
    assign o_point.last_point  = r_last;

    `SPTC_ASSERT_SAME(a_coord_clamped, i_clk, i_rst_n, r_valid,
        (r_x != 17'h10000) && (r_y != 17'h10000), "coordinate outside +-65535")

endmodule

// ===== rtl/core/scan_polar_to_cartesian_top.sv =====
// channel   dir  payload                                       handshake
// i_scan    in   range_mm, scan_start, sensor_in               valid/ready
// o_point   out  x_mm, y_mm, z_mm, point_index, sensor_out,    valid/ready
//                last_point
// i_cfg     in   index, data                                   valid/ready
//
// one item per cycle sustained while the output is not held; an item passes
// the start-vector stage, one cell per rotation stage, then the output register
// synchronous active-low reset clears valids, scan index and angle offset
// no clearing pass; the first item is taken in the cycle after reset
// empty stages keep filling while a result waits; i_scan.ready falls only
// when every stage is full and the output is held
// samples past the point limit update the scan state but give no point
`include "scan_polar_to_cartesian_top_macros.svh"

module scan_polar_to_cartesian_top #(
    parameter int MAX_POINTS    = 4096,
    parameter int CORDIC_STAGES = 18
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sptc_in_if.sink    i_scan,
    sptc_out_if.source o_point,
    sptc_cfg_if.sink   i_cfg
);

    localparam int NSTG = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

    sptc_pkg::t_cfg   r_cfg;
    sptc_pkg::t_stage w_chain [0:NSTG];
    logic             w_adv   [0:NSTG];

    // configuration registers, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.angle_start <= '0;
            r_cfg.angle_step  <= '0;
            r_cfg.points      <= '0;
            r_cfg.height      <= sptc_pkg::HEIGHT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                sptc_pkg::CFG_ANGLE_START: r_cfg.angle_start <= i_cfg.data;
                sptc_pkg::CFG_ANGLE_STEP:  r_cfg.angle_step  <= i_cfg.data;
                sptc_pkg::CFG_POINTS:      r_cfg.points      <= i_cfg.data[12:0];
                sptc_pkg::CFG_HEIGHT:      r_cfg.height      <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    // scan state and start vector
    sptc_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_scan   (i_scan),
        .i_cfg    (r_cfg),
        .i_adv_dn (w_adv[0]),
        .o_stage  (w_chain[0])
    );

    // row of rotation cells
    for (genvar k = 0; k < NSTG; k++) begin : g_cell
        sptc_cell #(
            .STAGE (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_stage  (w_chain[k]),
            .i_adv_dn (w_adv[k+1]),
            .o_adv_up (w_adv[k]),
            .o_stage  (w_chain[k+1])
        );
    end

    // rounding, quadrant and output register
    sptc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stage  (w_chain[NSTG]),
        .i_height (r_cfg.height),
        .o_adv_up (w_adv[NSTG]),
        .o_point  (o_point)
    );

    `SPTC_ASSERT_SAME(a_stall_only_when_full, i_clk, i_rst_n, !i_scan.ready,
        o_point.valid && !o_point.ready, "input stalled with output free")

endmodule
